/* rtl/thsp_pkg.sv */
// ----------------------------------------------------------------------------
// thsp_pkg
// Shared types, codes and helpers for the 3D halo tile generator.
// ----------------------------------------------------------------------------
package thsp_pkg;

    localparam int DIM_W   = 13;
    localparam int HALO_W  = 12;
    localparam int MAX_DIM = 4096;

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_TILE   = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOL_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALO_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALO_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALO_Z = 3'd5;

    // Reset values
    localparam logic [DIM_W-1:0]  VOL_RST  = 13'd256;
    localparam logic [HALO_W-1:0] HALO_RST = 12'd0;

    typedef struct packed {
        logic              req_type;
        logic [DIM_W-1:0]  tile_x;
        logic [DIM_W-1:0]  tile_y;
        logic [DIM_W-1:0]  tile_z;
    } in_word_t;

    typedef struct packed {
        logic [HALO_W-1:0] ext_start_x;
        logic [HALO_W-1:0] ext_start_y;
        logic [HALO_W-1:0] ext_start_z;
        logic [DIM_W-1:0]  ext_size_x;
        logic [DIM_W-1:0]  ext_size_y;
        logic [DIM_W-1:0]  ext_size_z;
        logic [2:0]        left_halo_mask;
        logic [DIM_W-1:0]  core_size_x;
        logic [DIM_W-1:0]  core_size_y;
        logic [DIM_W-1:0]  core_size_z;
        logic              last_tile;
        logic [1:0]        status;
    } out_word_t;

    // Register file contents seen by the tile datapath
    typedef struct packed {
        logic [DIM_W-1:0]  vol_x;
        logic [DIM_W-1:0]  vol_y;
        logic [DIM_W-1:0]  vol_z;
        logic [HALO_W-1:0] halo_x;
        logic [HALO_W-1:0] halo_y;
        logic [HALO_W-1:0] halo_z;
    } thsp_cfg_t;

    // Limit a size to the largest supported dimension
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v > DIM_W'(MAX_DIM))
            return DIM_W'(MAX_DIM);
        return v;
    endfunction

    // Volume extent: clamp, and treat zero as one
    function automatic logic [DIM_W-1:0] vol_extent(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] c;
        c = clamp_dim(v);
        if (c == '0)
            return DIM_W'(1);
        return c;
    endfunction

endpackage

/* rtl/thsp_axis.sv */
// ----------------------------------------------------------------------------
// thsp_axis
// Core and extended region geometry along one axis.
// ----------------------------------------------------------------------------
module thsp_axis (
    input  logic [thsp_pkg::DIM_W-1:0]  start,
    input  logic [thsp_pkg::DIM_W-1:0]  step,
    input  logic [thsp_pkg::DIM_W-1:0]  vol,
    input  logic [thsp_pkg::HALO_W-1:0] halo,
    output logic [thsp_pkg::HALO_W-1:0] ext_start,
    output logic [thsp_pkg::DIM_W-1:0]  ext_size,
    output logic [thsp_pkg::DIM_W-1:0]  core_size,
    output logic                        left_flag
);
    import thsp_pkg::*;

    logic [DIM_W-1:0] halo_w;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] rest;
    logic [DIM_W-1:0] core;
    logic [DIM_W-1:0] end_pos;
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] ext_start_w;
    logic [DIM_W:0]   size_sum;

    always_comb
    begin
        halo_w    = {1'b0, halo};
        left_flag = (start != '0);
        // limit the left halo to the core start
        if (!left_flag)
            left = '0;
        else if (halo_w < start)
            left = halo_w;
        else
            left = start;
        rest    = vol - start;
        core    = (step < rest) ? step : rest;
        end_pos = start + core;
        room    = vol - end_pos;
        right   = (halo_w < room) ? halo_w : room;
        ext_start_w = start - left;
        size_sum    = {1'b0, left} + {1'b0, core} + {1'b0, right};
    end

    assign ext_start = ext_start_w[HALO_W-1:0];
    assign ext_size  = size_sum[DIM_W-1:0];
    assign core_size = core;

endmodule

/* rtl/thsp_walk.sv */
// ----------------------------------------------------------------------------
// thsp_walk
// Walk counters and tile result for one request, z innermost, x outermost.
// ----------------------------------------------------------------------------
module thsp_walk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  thsp_pkg::in_word_t   req,
    input  thsp_pkg::thsp_cfg_t  cfg,
    output thsp_pkg::out_word_t  res
);
    import thsp_pkg::*;

    logic [DIM_W-1:0] core_start_x_reg, core_start_y_reg, core_start_z_reg;
    logic [DIM_W-1:0] core_start_x_next, core_start_y_next, core_start_z_next;
    logic [DIM_W-1:0] step_x_reg, step_y_reg, step_z_reg;
    logic             walk_active_reg, walk_active_next;

    logic             is_start;
    logic             reject;
    logic             active;
    logic             in_range;
    logic [DIM_W-1:0] vx, vy, vz;
    logic [DIM_W-1:0] tx, ty, tz;
    logic [DIM_W-1:0] st_x, st_y, st_z;
    logic [DIM_W-1:0] pos_x, pos_y, pos_z;
    logic [DIM_W:0]   sum_x, sum_y, sum_z;
    logic             wrap_x, wrap_y, wrap_z;
    logic             last;

    logic [HALO_W-1:0] es_x, es_y, es_z;
    logic [DIM_W-1:0]  ez_x, ez_y, ez_z;
    logic [DIM_W-1:0]  cs_x, cs_y, cs_z;
    logic [2:0]        mask;

    always_comb
    begin
        vx = vol_extent(cfg.vol_x);
        vy = vol_extent(cfg.vol_y);
        vz = vol_extent(cfg.vol_z);
        tx = clamp_dim(req.tile_x);
        ty = clamp_dim(req.tile_y);
        tz = clamp_dim(req.tile_z);
        is_start = (req.req_type == REQ_START);
        reject   = (tx <= {1'b0, cfg.halo_x}) || (ty <= {1'b0, cfg.halo_y}) ||
                   (tz <= {1'b0, cfg.halo_z});
        // a start request restarts the walk from the origin with new steps
        st_x  = is_start ? tx : step_x_reg;
        st_y  = is_start ? ty : step_y_reg;
        st_z  = is_start ? tz : step_z_reg;
        pos_x = is_start ? '0 : core_start_x_reg;
        pos_y = is_start ? '0 : core_start_y_reg;
        pos_z = is_start ? '0 : core_start_z_reg;
        active   = is_start ? !reject : walk_active_reg;
        in_range = (pos_x < vx) && (pos_y < vy) && (pos_z < vz);
        sum_x  = {1'b0, pos_x} + {1'b0, st_x};
        sum_y  = {1'b0, pos_y} + {1'b0, st_y};
        sum_z  = {1'b0, pos_z} + {1'b0, st_z};
        wrap_x = (sum_x >= {1'b0, vx});
        wrap_y = (sum_y >= {1'b0, vy});
        wrap_z = (sum_z >= {1'b0, vz});
        last   = wrap_z && wrap_y && wrap_x;
    end

    thsp_axis u_axis_x (
        .start     (pos_x),
        .step      (st_x),
        .vol       (vx),
        .halo      (cfg.halo_x),
        .ext_start (es_x),
        .ext_size  (ez_x),
        .core_size (cs_x),
        .left_flag (mask[0])
    );

    thsp_axis u_axis_y (
        .start     (pos_y),
        .step      (st_y),
        .vol       (vy),
        .halo      (cfg.halo_y),
        .ext_start (es_y),
        .ext_size  (ez_y),
        .core_size (cs_y),
        .left_flag (mask[1])
    );

    thsp_axis u_axis_z (
        .start     (pos_z),
        .step      (st_z),
        .vol       (vz),
        .halo      (cfg.halo_z),
        .ext_start (es_z),
        .ext_size  (ez_z),
        .core_size (cs_z),
        .left_flag (mask[2])
    );

    always_comb
    begin
        res               = '0;
        core_start_x_next = pos_x;
        core_start_y_next = pos_y;
        core_start_z_next = pos_z;
        walk_active_next  = 1'b0;
        priority if (is_start && reject)
        begin
            res.status = ST_REJECT;
        end
        else if (!active || !in_range)
        begin
            res.status = ST_IDLE;
        end
        else
        begin
            res.ext_start_x    = es_x;
            res.ext_start_y    = es_y;
            res.ext_start_z    = es_z;
            res.ext_size_x     = ez_x;
            res.ext_size_y     = ez_y;
            res.ext_size_z     = ez_z;
            res.left_halo_mask = mask;
            res.core_size_x    = cs_x;
            res.core_size_y    = cs_y;
            res.core_size_z    = cs_z;
            res.last_tile      = last;
            res.status         = ST_TILE;
            // advance z, carry into y, then x
            core_start_z_next = wrap_z ? '0 : sum_z[DIM_W-1:0];
            if (wrap_z)
                core_start_y_next = wrap_y ? '0 : sum_y[DIM_W-1:0];
            if (wrap_z && wrap_y)
                core_start_x_next = wrap_x ? '0 : sum_x[DIM_W-1:0];
            walk_active_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_start_x_reg <= '0;
            core_start_y_reg <= '0;
            core_start_z_reg <= '0;
            step_x_reg       <= '0;
            step_y_reg       <= '0;
            step_z_reg       <= '0;
            walk_active_reg  <= 1'b0;
        end
        else if (adv)
        begin
            core_start_x_reg <= core_start_x_next;
            core_start_y_reg <= core_start_y_next;
            core_start_z_reg <= core_start_z_next;
            step_x_reg       <= st_x;
            step_y_reg       <= st_y;
            step_z_reg       <= st_z;
            walk_active_reg  <= walk_active_next;
        end
    end

endmodule

/* rtl/tile_halo_split_3d_core.sv */
// ----------------------------------------------------------------------------
// tile_halo_split_3d_core
// Overlapped 3D tile generator: per request, a tile with halo or a status word.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input stage register, and its
//   result word is then registered in the output register.
// Throughput: one request per cycle unless out_stall holds the output; the
//   walk counters update in the same cycle as the tile math, so consecutive
//   requests chain without bubbles. Reset: walk idle, counters and steps zero,
//   volumes 256, halos 0; both pipeline registers empty.
// ----------------------------------------------------------------------------
module tile_halo_split_3d_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  thsp_pkg::in_word_t                in_word,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output thsp_pkg::out_word_t               out_word,
    // register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [thsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [thsp_pkg::DIM_W-1:0]        cfg_data
);
    import thsp_pkg::*;

    // Register file
    thsp_cfg_t cfg_reg;

    // Input stage
    in_word_t  s1_word_reg;
    logic      s1_vld_reg;
    logic      s1_vld_next;

    // Output stage
    out_word_t out_word_reg;
    logic      out_vld_reg;
    logic      out_vld_next;

    out_word_t res;
    logic      adv;
    logic      load;

    // Registers are always writable; the host must write them only while no
    // request is in flight. The block itself does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vol_x  <= VOL_RST;
            cfg_reg.vol_y  <= VOL_RST;
            cfg_reg.vol_z  <= VOL_RST;
            cfg_reg.halo_x <= HALO_RST;
            cfg_reg.halo_y <= HALO_RST;
            cfg_reg.halo_z <= HALO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_VOL_X:  cfg_reg.vol_x  <= cfg_data;
                REG_VOL_Y:  cfg_reg.vol_y  <= cfg_data;
                REG_VOL_Z:  cfg_reg.vol_z  <= cfg_data;
                REG_HALO_X: cfg_reg.halo_x <= cfg_data[HALO_W-1:0];
                REG_HALO_Y: cfg_reg.halo_y <= cfg_data[HALO_W-1:0];
                REG_HALO_Z: cfg_reg.halo_z <= cfg_data[HALO_W-1:0];
                default:    ;   // drop writes to unused indexes
            endcase
        end
    end

    // Advance the held request when the output register is empty or draining.
    assign adv      = s1_vld_reg && (!out_vld_reg || !out_stall);
    // Stall only when a request is held and cannot move on this cycle.
    assign in_stall = s1_vld_reg && !adv;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (load)
            s1_vld_next = 1'b1;
        else if (adv)
            s1_vld_next = 1'b0;
        else
            s1_vld_next = s1_vld_reg;

        if (adv)
            out_vld_next = 1'b1;
        else if (out_stall)
            out_vld_next = out_vld_reg;
        else
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            s1_word_reg <= in_word;
        if (adv)
            out_word_reg <= res;
    end

    // Tile math and walk state; state updates on the same edge as the result.
    thsp_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (s1_word_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

    // A stall on the input side means a request is parked in the input stage.
    a_stall_has_word : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_vld_reg)
        else $error("input stalled with empty input stage");

    // Every request that leaves the input stage shows up as a result word.
    a_adv_fills_out : assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("advanced request produced no result word");

    // Non-tile results carry no geometry flags.
    a_nontile_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_word_reg.status != ST_TILE) |->
            (!out_word_reg.last_tile && out_word_reg.left_halo_mask == 3'd0 &&
             out_word_reg.core_size_x == '0))
        else $error("status word carries tile fields");

    // A tile's extended region always covers a nonempty core.
    a_tile_covers_core : assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_word_reg.status == ST_TILE) |->
            (out_word_reg.core_size_x != '0 && out_word_reg.core_size_y != '0 &&
             out_word_reg.core_size_z != '0 &&
             out_word_reg.ext_size_x >= out_word_reg.core_size_x &&
             out_word_reg.ext_size_y >= out_word_reg.core_size_y &&
             out_word_reg.ext_size_z >= out_word_reg.core_size_z))
        else $error("extended region smaller than core");

endmodule

/* tb/sv/tile_halo_split_3d_core_tb.sv */
// ----------------------------------------------------------------------------
// tile_halo_split_3d_core_tb
// Self-checking bench for the 3D halo tile generator. A queue-fed driver
// offers request words with random gaps, a monitor takes result words under
// random stall and checks each one, field by field, against a tile walker
// kept inside the bench. Register settings change between phases, some of
// them in the middle of a walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tile_halo_split_3d_core_tb;

    import thsp_pkg::*;

    localparam int RANDOM_ITEMS    = 900;
    localparam int PHASE_ITEMS     = 45;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 10;

    // Index that decodes to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_word_t             in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    tile_halo_split_3d_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Tile walker: register copy, walk counters and the tile math.
    // Axis order in every array: 0 x, 1 y, 2 z.
    // ------------------------------------------------------------------------
    int vol_reg   [3] = '{256, 256, 256};
    int halo_reg  [3] = '{0, 0, 0};
    int walk_pos  [3] = '{0, 0, 0};
    int walk_step [3] = '{0, 0, 0};
    bit walking       = 1'b0;

    function automatic int clip_dim(input int v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic int vol_limit(input int v);
        return (v == 0) ? 1 : clip_dim(v);
    endfunction

    // Mirror a register write; halos keep only their low 12 bits.
    function automatic void set_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] val);
        case (idx)
            REG_VOL_X:  vol_reg[0]  = int'(val);
            REG_VOL_Y:  vol_reg[1]  = int'(val);
            REG_VOL_Z:  vol_reg[2]  = int'(val);
            REG_HALO_X: halo_reg[0] = int'(val[HALO_W-1:0]);
            REG_HALO_Y: halo_reg[1] = int'(val[HALO_W-1:0]);
            REG_HALO_Z: halo_reg[2] = int'(val[HALO_W-1:0]);
            default: ;
        endcase
    endfunction

    // One axis of a tile: clamp the core to the volume, then grow it by the
    // halo on each side. The left halo never reaches below zero.
    function automatic void axis_extent(input int start, input int step, input int lim,
                                        input int halo, output int ext_start,
                                        output int ext_size, output int core);
        int left;
        int right;
        left = 0;
        if (start != 0)
            left = (halo < start) ? halo : start;
        core = (step < lim - start) ? step : lim - start;
        right = lim - (start + core);
        if (halo < right)
            right = halo;
        ext_start = start - left;
        ext_size  = left + core + right;
    endfunction

    // Work out the result word for one request and advance the walk.
    function automatic out_word_t tile_for_request(input in_word_t req);
        out_word_t r;
        int        lim  [3];
        int        ext  [3];
        int        span [3];
        int        core [3];
        int        tile [3];
        bit        walk_ok;
        int        a;
        r = '0;
        for (a = 0; a < 3; a++)
            lim[a] = vol_limit(vol_reg[a]);

        if (req.req_type == REQ_START) begin
            tile[0] = clip_dim(int'(req.tile_x));
            tile[1] = clip_dim(int'(req.tile_y));
            tile[2] = clip_dim(int'(req.tile_z));
            walk_ok = 1'b1;
            for (a = 0; a < 3; a++) begin
                walk_step[a] = tile[a];
                walk_pos[a]  = 0;
                if (tile[a] <= halo_reg[a])
                    walk_ok = 1'b0;
            end
            walking = walk_ok;
            if (!walk_ok) begin
                r.status = ST_REJECT;
                return r;
            end
        end

        // No walk, or the volume shrank under the current position
        if (!walking || walk_pos[0] >= lim[0] || walk_pos[1] >= lim[1] ||
            walk_pos[2] >= lim[2]) begin
            walking  = 1'b0;
            r.status = ST_IDLE;
            return r;
        end

        for (a = 0; a < 3; a++)
            axis_extent(walk_pos[a], walk_step[a], lim[a], halo_reg[a],
                        ext[a], span[a], core[a]);
        r.left_halo_mask = {walk_pos[2] != 0, walk_pos[1] != 0, walk_pos[0] != 0};

        // Advance z first, carry into y, then x; the x carry ends the walk.
        walk_pos[2] += walk_step[2];
        if (walk_pos[2] >= lim[2]) begin
            walk_pos[2] = 0;
            walk_pos[1] += walk_step[1];
            if (walk_pos[1] >= lim[1]) begin
                walk_pos[1] = 0;
                walk_pos[0] += walk_step[0];
                if (walk_pos[0] >= lim[0]) begin
                    walk_pos[0] = 0;
                    r.last_tile = 1'b1;
                    walking     = 1'b0;
                end
            end
        end

        r.ext_start_x = ext[0][HALO_W-1:0];
        r.ext_start_y = ext[1][HALO_W-1:0];
        r.ext_start_z = ext[2][HALO_W-1:0];
        r.ext_size_x  = span[0][DIM_W-1:0];
        r.ext_size_y  = span[1][DIM_W-1:0];
        r.ext_size_z  = span[2][DIM_W-1:0];
        r.core_size_x = core[0][DIM_W-1:0];
        r.core_size_y = core[1][DIM_W-1:0];
        r.core_size_z = core[2][DIM_W-1:0];
        r.status      = ST_TILE;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------------
    in_word_t  req_q [$];          // request words not yet offered
    out_word_t pending_tiles [$];  // predicted result words, oldest first
    int        n_sent        = 0;
    int        n_acc         = 0;
    int        n_err         = 0;
    int        n_tile        = 0;
    int        n_last        = 0;
    int        n_idle        = 0;
    int        n_reject      = 0;
    int        n_cfg         = 0;
    int        in_gap_max    = 0;
    int        out_stall_max = 0;
    logic      pressure_arm  = 1'b0;

    // ------------------------------------------------------------------------
    // Driver: hold a word while stalled; on accept, predict its result, then
    // wait out the drawn gap before offering the next word.
    // ------------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
            gap_left <= 0;
        end
        else if (!(in_valid && in_stall)) begin
            if (in_valid) begin
                pending_tiles = {pending_tiles, tile_for_request(in_word)};
                n_acc++;
            end
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (req_q.size() != 0) begin
                in_word  <= req_q.pop_front();
                in_valid <= 1'b1;
                gap_left <= $urandom_range(0, in_gap_max);
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check accepted result words and shape the stall.
    // ------------------------------------------------------------------------
    task automatic field_check(input string name, input logic [DIM_W-1:0] want,
                               input logic [DIM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    task automatic check_tile(input out_word_t got);
        out_word_t want;
        if (pending_tiles.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            n_err++;
            return;
        end
        want = pending_tiles.pop_front();
        field_check("ext_start_x",    want.ext_start_x,    got.ext_start_x);
        field_check("ext_start_y",    want.ext_start_y,    got.ext_start_y);
        field_check("ext_start_z",    want.ext_start_z,    got.ext_start_z);
        field_check("ext_size_x",     want.ext_size_x,     got.ext_size_x);
        field_check("ext_size_y",     want.ext_size_y,     got.ext_size_y);
        field_check("ext_size_z",     want.ext_size_z,     got.ext_size_z);
        field_check("left_halo_mask", want.left_halo_mask, got.left_halo_mask);
        field_check("core_size_x",    want.core_size_x,    got.core_size_x);
        field_check("core_size_y",    want.core_size_y,    got.core_size_y);
        field_check("core_size_z",    want.core_size_z,    got.core_size_z);
        field_check("last_tile",      want.last_tile,      got.last_tile);
        field_check("status",         want.status,         got.status);
        case (want.status)
            ST_TILE:   begin n_tile++; if (want.last_tile) n_last++; end
            ST_IDLE:   n_idle++;
            ST_REJECT: n_reject++;
            default: ;
        endcase
    endtask

    int   stall_left    = 0;
    int   hold_left     = 0;
    int   stall_draw    = 0;
    logic pressure_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall     <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            pressure_done <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall)
                check_tile(out_word);
            // Long hold: back the pipe up so the request side stalls too
            if (pressure_arm && !pressure_done) begin
                pressure_done <= 1'b1;
                out_stall     <= 1'b1;
                hold_left     <= PRESSURE_CYCLES;
            end
            else if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (out_valid && !out_stall) begin
                stall_draw = $urandom_range(0, out_stall_max);
                out_stall  <= (stall_draw != 0);
                stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
            end
            else if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no handshake on any channel.
    // ------------------------------------------------------------------------
    int quiet = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end
        else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** tile_halo_split_3d_core: FAILED **");
            $finish;
        end
        else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(input logic rt, input int tx, input int ty, input int tz);
        in_word_t w;
        w.req_type = rt;
        w.tile_x   = tx[DIM_W-1:0];
        w.tile_y   = ty[DIM_W-1:0];
        w.tile_z   = tz[DIM_W-1:0];
        req_q = {req_q, w};
        n_sent++;
    endtask

    // Next request; tile fields carry junk that the block must ignore.
    task automatic push_next();
        push_req(REQ_NEXT, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191));
    endtask

    // Hold valid across back-to-back writes; the caller drops it afterwards.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_index <= idx;
        cfg_data  <= val[DIM_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_reg(idx, val[DIM_W-1:0]);
        n_cfg++;
    endtask

    task automatic wait_drained();
        while (n_acc != n_sent || pending_tiles.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int pick_vol();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(MAX_DIM + 1, 8191);
            2:       return MAX_DIM;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic int pick_halo();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 4095);
            1:       return $urandom_range(0, 8191);
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    task automatic random_reg(input logic [CFG_IDX_W-1:0] idx);
        if ($urandom_range(0, 3) != 0) begin
            if (idx == REG_VOL_X || idx == REG_VOL_Y || idx == REG_VOL_Z)
                reg_write(idx, pick_vol());
            else
                reg_write(idx, pick_halo());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stim
        int     ph;
        int     n;
        int     k;
        int     a;
        int     te;
        int     lim;
        int     tile [3];
        int     mode;
        longint ntiles;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: no walk, oversized tiles, finished walk, bad start
        push_next();
        push_req(REQ_START, 8191, 8191, 8191);
        push_next();
        push_req(REQ_START, 0, 5, 5);
        push_req(REQ_START, 100, 100, 200);
        push_next();
        push_next();
        wait_drained();

        // Extremes; the walk above goes on with a raised y halo
        reg_write(REG_VOL_X, 0);
        reg_write(REG_VOL_Y, 8191);
        reg_write(REG_VOL_Z, MAX_DIM);
        reg_write(REG_HALO_X, 0);
        reg_write(REG_HALO_Y, 4095);
        reg_write(REG_HALO_Z, 1);
        reg_write(REG_UNUSED, 8191);
        cfg_valid <= 1'b0;
        push_next();
        push_req(REQ_START, 1, MAX_DIM, 2);
        push_next();
        push_next();
        push_req(REQ_START, 5, 4095, 5);
        push_req(REQ_START, 5, MAX_DIM, 1);
        wait_drained();

        // Halos on both sides, then shrink z under a live walk
        reg_write(REG_VOL_X, 20);
        reg_write(REG_VOL_Y, 20);
        reg_write(REG_VOL_Z, 20);
        reg_write(REG_HALO_X, 2);
        reg_write(REG_HALO_Y, 2);
        reg_write(REG_HALO_Z, 2);
        cfg_valid <= 1'b0;
        push_req(REQ_START, 8, 8, 8);
        push_next();
        push_next();
        push_next();
        wait_drained();
        reg_write(REG_VOL_Z, 4);
        cfg_valid <= 1'b0;
        push_next();
        push_next();
        wait_drained();

        // Tile just above the largest halo, and a start bad on x only
        reg_write(REG_VOL_X, 5);
        reg_write(REG_VOL_Y, 5);
        reg_write(REG_VOL_Z, 5);
        reg_write(REG_HALO_X, 4095);
        reg_write(REG_HALO_Y, 4095);
        reg_write(REG_HALO_Z, 4095);
        cfg_valid <= 1'b0;
        push_req(REQ_START, MAX_DIM, MAX_DIM, MAX_DIM);
        push_req(REQ_START, 100, MAX_DIM, MAX_DIM);
        wait_drained();

        // Random phases: new setting, then mostly well-formed walks
        ph = 0;
        while (n_sent < RANDOM_ITEMS + 25) begin
            mode          = $urandom_range(0, 3);
            in_gap_max    = mode[0] ? 10 : 0;
            out_stall_max = mode[1] ? 10 : 0;
            if (ph == 1) begin
                in_gap_max = 0;
                pressure_arm <= 1'b1;
            end
            random_reg(REG_VOL_X);
            random_reg(REG_VOL_Y);
            random_reg(REG_VOL_Z);
            random_reg(REG_HALO_X);
            random_reg(REG_HALO_Y);
            random_reg(REG_HALO_Z);
            cfg_valid <= 1'b0;

            n = 0;
            // Sometimes carry on the previous walk under the new setting
            if ($urandom_range(0, 1) != 0) begin
                k = $urandom_range(1, 4);
                repeat (k) push_next();
                n += k;
            end
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    push_req(1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                             $urandom_range(0, 8191), $urandom_range(0, 8191));
                    n++;
                end
                else begin
                    ntiles = 1;
                    for (a = 0; a < 3; a++) begin
                        lim = vol_limit(vol_reg[a]);
                        if ($urandom_range(0, 9) == 0)
                            tile[a] = $urandom_range(0, halo_reg[a]);
                        else
                            tile[a] = halo_reg[a] + 1 + $urandom_range(0, lim / 2 + 2);
                        te = clip_dim(tile[a]);
                        if (te == 0)
                            te = 1;
                        ntiles = ntiles * ((lim + te - 1) / te);
                        if (ntiles > 60)
                            ntiles = 61;
                    end
                    push_req(REQ_START, tile[0], tile[1], tile[2]);
                    k = $urandom_range(0, int'(ntiles) + 2);
                    repeat (k) push_next();
                    n += k + 1;
                end
            end
            wait_drained();
            ph++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests over %0d phases, %0d register writes, long output hold done: %0b",
                 n_acc, ph, n_cfg, pressure_done);
        $display("tiles %0d (walks finished %0d), idle %0d, rejected starts %0d",
                 n_tile, n_last, n_idle, n_reject);
        if (n_err == 0)
            $display("** tile_halo_split_3d_core: PASSED **");
        else
            $display("** tile_halo_split_3d_core: FAILED **");
        $finish;
    end

endmodule
